// ===== design/assert_macros.svh =====
// Assertion macros shared by the set block RTL.
// Needs signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define USID_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define USID_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/usid_pkg.sv =====
// Types, constants and codes of the set union/intersection/difference block.
// No dependencies.
package usid_pkg;

	localparam int SET_DEPTH = 32;
	localparam int ELEM_W    = 32;
	localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);

	typedef logic signed [ELEM_W-1:0] usid_elem_t;
	typedef logic [CNT_W-1:0]         usid_cnt_t;

	typedef enum logic [2:0] {
		CMD_INS_A     = 3'd0,
		CMD_INS_B     = 3'd1,
		CMD_UNION     = 3'd2,
		CMD_INTER     = 3'd3,
		CMD_A_MINUS_B = 3'd4,
		CMD_B_MINUS_A = 3'd5,
		CMD_CLEAR     = 3'd6,
		CMD_NOP       = 3'd7
	} usid_cmd_t;

	typedef enum logic [2:0] {
		ST_ELEMENT   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_CLEARED   = 3'd5
	} usid_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_TEST,
		S_FLUSH,
		S_CLEAR
	} usid_state_t;

	// set select: 0 = A, 1 = B
	typedef struct packed {
		logic wr_en;
		logic wr_sel;
		logic clr;
		logic rd_sel;
		logic cmp_sel;
	} usid_store_req_t;

endpackage

// ===== design/usid_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
// Depends on usid_pkg.
interface usid_req_if import usid_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       cmd;
	logic signed [ELEM_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface usid_rsp_if import usid_pkg::*; ();
	logic             valid;
	logic             ready;
	logic signed [ELEM_W-1:0] element;
	logic [2:0]       status;
	logic             last;

	modport source (output valid, output element, output status, output last, input ready);
	modport sink   (input valid, input element, input status, input last, output ready);
endinterface

// ===== design/usid_store.sv =====
// Register storage of sets A and B, their counts and the membership compare bank.
// Depends on usid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usid_store import usid_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  usid_store_req_t req,
	input  usid_elem_t      probe,
	input  logic [IDX_W-1:0] rd_idx,
	output usid_elem_t      rd_data,
	output logic            hit,
	output usid_cnt_t       cnt_a,
	output usid_cnt_t       cnt_b
);

	usid_elem_t set_a_q [SET_DEPTH];
	usid_elem_t set_b_q [SET_DEPTH];
	usid_cnt_t  cnt_a_q;
	usid_cnt_t  cnt_b_q;
	logic [SET_DEPTH-1:0] match_a;
	logic [SET_DEPTH-1:0] match_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else if (req.clr) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else if (req.wr_en) begin
			if (req.wr_sel) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end else begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && !req.clr) begin
			if (req.wr_sel) begin
				set_b_q[cnt_b_q[IDX_W-1:0]] <= probe;
			end else begin
				set_a_q[cnt_a_q[IDX_W-1:0]] <= probe;
			end
		end
	end

	for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cmp
		assign match_a[i] = (CNT_W'(i) < cnt_a_q) && (set_a_q[i] == probe);
		assign match_b[i] = (CNT_W'(i) < cnt_b_q) && (set_b_q[i] == probe);
	end

	assign hit     = req.cmp_sel ? |match_b : |match_a;
	assign rd_data = req.rd_sel ? set_b_q[rd_idx] : set_a_q[rd_idx];
	assign cnt_a   = cnt_a_q;
	assign cnt_b   = cnt_b_q;

	`USID_CHECK(a_cnt_bound, cnt_a_q <= CNT_W'(SET_DEPTH), "set A count above depth")
	`USID_CHECK(b_cnt_bound, cnt_b_q <= CNT_W'(SET_DEPTH), "set B count above depth")
	`USID_CHECK(a_cnt_step, cnt_a_q != $past(cnt_a_q) |-> cnt_a_q == '0 || cnt_a_q == $past(cnt_a_q) + CNT_W'(1), "set A count jumped")
	`USID_CHECK(b_cnt_step, cnt_b_q != $past(cnt_b_q) |-> cnt_b_q == '0 || cnt_b_q == $past(cnt_b_q) + CNT_W'(1), "set B count jumped")

endmodule

// ===== design/set_union_intersection_difference.sv =====
// Two ordered sets of signed 32-bit values (up to 32 members each) with insert, clear and
// union / intersection / difference queries; a query answers with a run of element
// transactions whose final one carries last, or a single empty marker. One command is taken
// at a time. Insert and clear each answer with one status result. A query scans the
// source set(s) one entry at a time in S_SCAN and S_TEST, reading one entry and testing it against
// the other set in a single parallel compare bank (a union's first pass, over A, keeps every entry
// untested); a stalled result channel holds the scan.
// Results leave through an output register. Depends on usid_pkg, usid_if, usid_store.
`include "assert_macros.svh"

module set_union_intersection_difference import usid_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	usid_req_if.sink     req,
	usid_rsp_if.source   rsp
);

	usid_state_t     state_q, state_d;
	usid_cmd_t       cmd_q;
	usid_cnt_t       idx_q;
	logic            phase_q;
	usid_elem_t      probe_q;
	usid_elem_t      pend_q;
	logic            pend_vld_q;
	logic            out_vld_q;
	usid_elem_t      out_elem_q;
	usid_status_t    out_stat_q;
	logic            out_last_q;

	usid_store_req_t st_req;
	usid_elem_t      rd_data;
	logic            hit;
	usid_cnt_t       cnt_a, cnt_b;

	logic            in_acc, out_free;
	logic            src_b, cmp_off, keep_in, keep, scan_end, ins_b, full;
	usid_cnt_t       src_cnt, tgt_cnt;

	logic            emit;
	usid_elem_t      emit_elem;
	usid_status_t    emit_stat;
	logic            emit_last;
	logic            probe_ld, idx_clr, idx_inc, phase_set, pend_ld;

	usid_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (st_req),
		.probe   (probe_q),
		.rd_idx  (idx_q[IDX_W-1:0]),
		.rd_data (rd_data),
		.hit     (hit),
		.cnt_a   (cnt_a),
		.cnt_b   (cnt_b)
	);

	assign req.ready = (state_q == S_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	assign src_b    = (cmd_q == CMD_INTER) || (cmd_q == CMD_B_MINUS_A) ||
	                  ((cmd_q == CMD_UNION) && phase_q);
	assign cmp_off  = (cmd_q == CMD_UNION) && !phase_q;
	assign keep_in  = (cmd_q == CMD_INTER);
	assign keep     = cmp_off || (hit == keep_in);
	assign src_cnt  = src_b ? cnt_b : cnt_a;
	assign scan_end = (idx_q >= src_cnt);
	assign ins_b    = (cmd_q == CMD_INS_B);
	assign tgt_cnt  = ins_b ? cnt_b : cnt_a;
	assign full     = (tgt_cnt >= CNT_W'(SET_DEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (usid_cmd_t'(req.cmd))
						CMD_INS_A, CMD_INS_B: state_d = S_INS;
						CMD_UNION, CMD_INTER,
						CMD_A_MINUS_B, CMD_B_MINUS_A: state_d = S_SCAN;
						CMD_CLEAR: state_d = S_CLEAR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS, S_FLUSH, S_CLEAR: begin
				if (out_free) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (!scan_end) begin
					state_d = S_TEST;
				end else if (!cmp_off) begin
					state_d = S_FLUSH;
				end
			end
			S_TEST: begin
				if (!(keep && pend_vld_q && !out_free)) state_d = S_SCAN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		st_req         = '0;
		st_req.rd_sel  = src_b;
		st_req.cmp_sel = (state_q == S_INS) ? ins_b : !src_b;
		st_req.wr_sel  = ins_b;
		emit      = 1'b0;
		emit_elem = '0;
		emit_stat = ST_ELEMENT;
		emit_last = 1'b1;
		probe_ld  = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		phase_set = 1'b0;
		pend_ld   = 1'b0;
		case (state_q)
			S_INS: begin
				if (out_free) begin
					emit         = 1'b1;
					emit_stat    = hit ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
					st_req.wr_en = !hit && !full;
				end
			end
			S_CLEAR: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_stat  = ST_CLEARED;
					st_req.clr = 1'b1;
				end
			end
			S_SCAN: begin
				if (!scan_end) begin
					probe_ld = 1'b1;
				end else if (cmp_off) begin
					phase_set = 1'b1;
					idx_clr   = 1'b1;
				end
			end
			S_TEST: begin
				if (!keep) begin
					idx_inc = 1'b1;
				end else if (!pend_vld_q || out_free) begin
					emit      = pend_vld_q;
					emit_elem = pend_q;
					emit_last = 1'b0;
					pend_ld   = 1'b1;
					idx_inc   = 1'b1;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_elem = pend_vld_q ? pend_q : '0;
					emit_stat = pend_vld_q ? ST_ELEMENT : ST_EMPTY;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= CMD_NOP;
			idx_q      <= '0;
			phase_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cmd_q      <= usid_cmd_t'(req.cmd);
				idx_q      <= '0;
				phase_q    <= 1'b0;
				pend_vld_q <= 1'b0;
			end else begin
				if (idx_clr) idx_q <= '0;
				else if (idx_inc) idx_q <= idx_q + CNT_W'(1);
				if (phase_set) phase_q <= 1'b1;
				if (pend_ld) pend_vld_q <= 1'b1;
			end
			if (emit) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) probe_q <= req.value;
		else if (probe_ld) probe_q <= rd_data;
		if (pend_ld) pend_q <= probe_q;
		if (emit) begin
			out_elem_q <= emit_elem;
			out_stat_q <= emit_stat;
			out_last_q <= emit_last;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.element = out_elem_q;
	assign rsp.status  = out_stat_q;
	assign rsp.last    = out_last_q;

	`USID_CHECK(non_elem_is_last, out_vld_q && out_stat_q != ST_ELEMENT |-> out_last_q, "status transaction without last")
	`USID_CHECK(busy_after_cmd, in_acc && req.cmd != CMD_NOP |=> !req.ready, "ready held after command")
	`USID_CHECK(elem_from_query, emit && emit_stat == ST_ELEMENT |-> state_q == S_TEST || state_q == S_FLUSH, "element outside a query")
	`USID_NEVER(emit_while_blocked, emit && out_vld_q && !rsp.ready, "result overwritten")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for set_union_intersection_difference: an in-bench model of the two
// ordered sets predicts every result transaction, checked in order as the block emits them.
// Depends on usid_pkg, usid_if and the block RTL.
module testbench;
	import usid_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam usid_elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
	localparam usid_elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

	typedef struct {
		usid_elem_t   element;
		usid_status_t status;
		logic         last;
	} set_result_t;

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   mismatches = 0;
	int   hold_requests = 0;
	bit   no_idle = 1'b0;

	usid_elem_t  set_a[$];
	usid_elem_t  set_b[$];
	set_result_t pending_results[$];

	usid_req_if req();
	usid_rsp_if rsp();

	set_union_intersection_difference dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("set_union_intersection_difference test failed");
		$finish;
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic usid_elem_t rand_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return usid_elem_t'(int'($urandom_range(0, 47)) - 24);
		else if (r < 8)
			return usid_elem_t'($urandom);
		case ($urandom_range(0, 3))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic bit holds(usid_elem_t s[$], usid_elem_t v);
		foreach (s[i])
			if (s[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void expect_result(usid_elem_t e, usid_status_t st, logic lst);
		set_result_t r;
		r.element = e;
		r.status  = st;
		r.last    = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_sets(usid_cmd_t c, usid_elem_t v);
		usid_elem_t tgt[$];
		usid_elem_t run[$];
		bit         into_b;
		case (c)
			CMD_INS_A, CMD_INS_B: begin
				into_b = (c == CMD_INS_B);
				tgt = into_b ? set_b : set_a;
				if (holds(tgt, v)) begin
					expect_result('0, ST_DUPLICATE, 1'b1);
				end else if (tgt.size() >= SET_DEPTH) begin
					expect_result('0, ST_FULL, 1'b1);
				end else begin
					tgt.push_back(v);
					if (into_b)
						set_b = tgt;
					else
						set_a = tgt;
					expect_result('0, ST_INSERTED, 1'b1);
				end
			end
			CMD_CLEAR: begin
				set_a.delete();
				set_b.delete();
				expect_result('0, ST_CLEARED, 1'b1);
			end
			CMD_UNION, CMD_INTER, CMD_A_MINUS_B, CMD_B_MINUS_A: begin
				if (c == CMD_UNION) begin
					run = set_a;
					foreach (set_b[i])
						if (!holds(set_a, set_b[i]))
							run.push_back(set_b[i]);
				end else if (c == CMD_INTER) begin
					foreach (set_b[i])
						if (holds(set_a, set_b[i]))
							run.push_back(set_b[i]);
				end else if (c == CMD_A_MINUS_B) begin
					foreach (set_a[i])
						if (!holds(set_b, set_a[i]))
							run.push_back(set_a[i]);
				end else begin
					foreach (set_b[i])
						if (!holds(set_a, set_b[i]))
							run.push_back(set_b[i]);
				end
				if (run.size() == 0)
					expect_result('0, ST_EMPTY, 1'b1);
				else
					foreach (run[i])
						expect_result(run[i], ST_ELEMENT, i == run.size() - 1);
			end
			default: begin
			end
		endcase
	endfunction

	// Leaves valid high on return so back-to-back transactions need no gap.
	task automatic send_cmd(usid_cmd_t c, usid_elem_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd   <= c;
		req.value <= v;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		predict_sets(c, v);
	endtask

	// Result side: random stalls after transactions, plus long hold-offs on request.
	initial begin
		int stall_left;
		int holds_served;
		stall_left = 0;
		holds_served = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		set_result_t want;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transaction: element %0d status %0d last %0d",
						rsp.element, rsp.status, rsp.last);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.element !== want.element) begin
						$error("element: expected %0d, got %0d", want.element, rsp.element);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic test_empty_sets();
		send_cmd(CMD_UNION, '0);
		send_cmd(CMD_INTER, '1);
		send_cmd(CMD_A_MINUS_B, ELEM_MIN);
		send_cmd(CMD_B_MINUS_A, ELEM_MAX);
		send_cmd(CMD_NOP, ELEM_MAX);
		send_cmd(CMD_CLEAR, ELEM_MIN);
	endtask

	task automatic test_extremes();
		send_cmd(CMD_INS_A, ELEM_MIN);
		send_cmd(CMD_INS_A, ELEM_MAX);
		send_cmd(CMD_INS_A, '0);
		send_cmd(CMD_INS_A, '1);
		send_cmd(CMD_INS_B, ELEM_MAX);
		send_cmd(CMD_INS_B, usid_elem_t'(1));
		send_cmd(CMD_INS_A, ELEM_MAX);
		send_cmd(CMD_INS_B, usid_elem_t'(1));
		send_cmd(CMD_UNION, '0);
		send_cmd(CMD_INTER, '0);
		send_cmd(CMD_A_MINUS_B, '0);
		send_cmd(CMD_B_MINUS_A, '0);
		send_cmd(CMD_NOP, usid_elem_t'($urandom));
		send_cmd(CMD_CLEAR, '0);
		send_cmd(CMD_UNION, '0);
	endtask

	// Full sets: duplicate is reported ahead of full, and a union yields the longest run.
	task automatic test_full_sets();
		send_cmd(CMD_CLEAR, '0);
		while (set_a.size() < SET_DEPTH)
			send_cmd(CMD_INS_A, rand_value());
		send_cmd(CMD_INS_A, usid_elem_t'($urandom));
		send_cmd(CMD_INS_A, set_a[0]);
		while (set_b.size() < SET_DEPTH)
			send_cmd(CMD_INS_B, $urandom_range(0, 1) ?
				set_a[$urandom_range(0, SET_DEPTH - 1)] : usid_elem_t'($urandom));
		send_cmd(CMD_INS_B, usid_elem_t'($urandom));
		send_cmd(CMD_INS_B, set_b[SET_DEPTH - 1]);
		send_cmd(CMD_UNION, rand_value());
		send_cmd(CMD_INTER, rand_value());
		send_cmd(CMD_A_MINUS_B, rand_value());
		send_cmd(CMD_B_MINUS_A, rand_value());
		send_cmd(CMD_CLEAR, rand_value());
	endtask

	task automatic test_random_mix();
		int unsigned r;
		usid_cmd_t   c;
		for (int n = 0; n < 30; n++) begin
			no_idle = (n < 10);
			r = $urandom_range(0, 99);
			if (r < 25)
				c = CMD_INS_A;
			else if (r < 50)
				c = CMD_INS_B;
			else if (r < 62)
				c = CMD_UNION;
			else if (r < 70)
				c = CMD_INTER;
			else if (r < 78)
				c = CMD_A_MINUS_B;
			else if (r < 86)
				c = CMD_B_MINUS_A;
			else if (r < 91)
				c = CMD_CLEAR;
			else if (r < 95)
				c = CMD_NOP;
			else
				c = usid_cmd_t'($urandom_range(0, 7));
			send_cmd(c, rand_value());
		end
		no_idle = 1'b0;
	endtask

	// Result side held off while commands keep coming, so the block backs up.
	task automatic test_output_stall();
		for (int n = 0; n < 6; n++) begin
			send_cmd(CMD_INS_A, rand_value());
			send_cmd(CMD_INS_B, rand_value());
		end
		hold_requests <= hold_requests + 1;
		send_cmd(CMD_UNION, '0);
		send_cmd(CMD_INTER, '0);
		send_cmd(CMD_INS_A, rand_value());
		send_cmd(CMD_A_MINUS_B, '0);
		send_cmd(CMD_B_MINUS_A, '0);
		send_cmd(CMD_CLEAR, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_NOP;
		req.value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_sets();
		test_extremes();
		test_full_sets();
		test_random_mix();
		test_output_stall();

		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("set_union_intersection_difference test passed");
		else
			$display("set_union_intersection_difference test failed");
		$finish;
	end

endmodule
